// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define QWT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tokenizer assertion failed");

// Condition that must never be true outside reset.
`define QWT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tokenizer forbidden condition seen");

`else

`define QWT_ASSERT(label, clk, rst_n, prop)
`define QWT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- hw/rtl/qwt_pkg.sv -----
package qwt_pkg;

	localparam int CHAR_W = 8;
	localparam int LEN_W  = 10;
	localparam int CNT_W  = 6;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [LEN_W-1:0] LEN_LIMIT_RST = 10'd1023;
	localparam logic [CNT_W-1:0] CNT_LIMIT_RST = 6'd59;

	localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
	localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;

	// Configuration register indexes.
	localparam logic [0:0] REG_LEN_LIMIT = 1'b0;
	localparam logic [0:0] REG_CNT_LIMIT = 1'b1;

	// Result queue geometry.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		QM_OUT    = 2'd0,
		QM_SINGLE = 2'd1,
		QM_DOUBLE = 2'd2
	} qmode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_OPEN_QUOTE = 2'd1,
		ST_TOO_LONG   = 2'd2,
		ST_TOO_MANY   = 2'd3
	} status_t;

	typedef struct packed {
		logic [CHAR_W-1:0] word_char;
		logic              char_valid;
		logic              word_end;
		logic              line_end;
		status_t           status;
	} res_t;

	// Up to two results produced by one input item; vld[1] implies vld[0].
	typedef struct packed {
		logic [1:0] vld;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] len);
		len_inc = (len == LEN_MAX) ? len : len + LEN_W'(1);
	endfunction

	function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] cnt);
		cnt_inc = (cnt == CNT_MAX) ? cnt : cnt + CNT_W'(1);
	endfunction

	function automatic status_t limit_check(input logic [LEN_W-1:0] len,
		input logic [CNT_W-1:0] cnt, input logic [LEN_W-1:0] len_lim,
		input logic [CNT_W-1:0] cnt_lim);
		if (len >= len_lim) begin
			limit_check = ST_TOO_LONG;
		end else if (cnt >= cnt_lim) begin
			limit_check = ST_TOO_MANY;
		end else begin
			limit_check = ST_OK;
		end
	endfunction

	function automatic res_t char_res(input logic [CHAR_W-1:0] c);
		char_res            = '0;
		char_res.word_char  = c;
		char_res.char_valid = 1'b1;
	endfunction

endpackage

// ----- hw/rtl/qwt_if.sv -----
interface qwt_in_if (input logic clk);
	logic                      valid;
	logic                      ready;
	logic [qwt_pkg::CHAR_W-1:0] ch;
	logic                      line_done;

	modport source (output valid, ch, line_done, input ready);
	modport sink (input valid, ch, line_done, output ready);
endinterface

interface qwt_out_if (input logic clk);
	logic                      valid;
	logic                      ready;
	logic [qwt_pkg::CHAR_W-1:0] word_char;
	logic                      char_valid;
	logic                      word_end;
	logic                      line_end;
	logic [1:0]                status;

	modport source (output valid, word_char, char_valid, word_end, line_end, status,
		input ready);
	modport sink (input valid, word_char, char_valid, word_end, line_end, status,
		output ready);
endinterface

// ----- hw/rtl/qwt_core.sv -----
`include "assert_macros.svh"

module qwt_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [qwt_pkg::LEN_W-1:0]  cfg_data,
	input  logic                       in_valid,
	input  logic [qwt_pkg::CHAR_W-1:0] in_ch,
	input  logic                       in_done,
	output logic                       in_ready,
	input  logic                       room,
	output qwt_pkg::push_t             push
);

	logic [qwt_pkg::LEN_W-1:0]  len_limit_q;
	logic [qwt_pkg::CNT_W-1:0]  cnt_limit_q;

	logic                       valid_s1;
	logic [qwt_pkg::CHAR_W-1:0] ch_s1;
	logic                       done_s1;

	qwt_pkg::qmode_t            qm_q, qm_d;
	logic                       pend_q, pend_d;
	logic [qwt_pkg::LEN_W-1:0]  len_q, len_d;
	logic [qwt_pkg::CNT_W-1:0]  cnt_q, cnt_d;
	qwt_pkg::status_t           err_q, err_d;

	logic                       fire;

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_limit_q <= qwt_pkg::LEN_LIMIT_RST;
			cnt_limit_q <= qwt_pkg::CNT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				qwt_pkg::REG_LEN_LIMIT: len_limit_q <= cfg_data;
				qwt_pkg::REG_CNT_LIMIT: cnt_limit_q <= cfg_data[qwt_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1   <= in_ch;
			done_s1 <= in_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qm_q   <= qwt_pkg::QM_OUT;
			pend_q <= 1'b0;
			len_q  <= '0;
			cnt_q  <= '0;
			err_q  <= qwt_pkg::ST_OK;
		end else if (fire) begin
			qm_q   <= qm_d;
			pend_q <= pend_d;
			len_q  <= len_d;
			cnt_q  <= cnt_d;
			err_q  <= err_d;
		end
	end

	always_comb begin
		logic [qwt_pkg::LEN_W-1:0] len1;
		logic [qwt_pkg::CNT_W-1:0] cnt1;
		qwt_pkg::status_t          mid;
		qwt_pkg::status_t          st;
		logic                      closed;
		logic                      is_sep;

		len1   = qwt_pkg::len_inc(len_q);
		cnt1   = qwt_pkg::cnt_inc(cnt_q);
		mid    = qwt_pkg::limit_check(len1, cnt_q, len_limit_q, cnt_limit_q);
		is_sep = (ch_s1 == qwt_pkg::CH_SPACE) || (ch_s1 == qwt_pkg::CH_TAB);
		st     = err_q;
		closed = 1'b0;

		qm_d   = qm_q;
		pend_d = pend_q;
		len_d  = len_q;
		cnt_d  = cnt_q;
		err_d  = err_q;
		push   = '0;

		if (done_s1) begin
			if (err_q == qwt_pkg::ST_OK) begin
				if (qm_q != qwt_pkg::QM_OUT) begin
					st = qwt_pkg::ST_OPEN_QUOTE;
				end else if (len_q != '0) begin
					closed = 1'b1;
					st = qwt_pkg::limit_check('0, cnt1, len_limit_q, cnt_limit_q);
				end else begin
					st = qwt_pkg::limit_check('0, cnt_q, len_limit_q, cnt_limit_q);
				end
			end
			push.vld[0]       = 1'b1;
			push.r0.word_end  = closed;
			push.r0.line_end  = 1'b1;
			push.r0.status    = st;
			qm_d   = qwt_pkg::QM_OUT;
			pend_d = 1'b0;
			len_d  = '0;
			cnt_d  = '0;
			err_d  = qwt_pkg::ST_OK;
		end else if (err_q == qwt_pkg::ST_OK) begin
			case (qm_q)
				qwt_pkg::QM_SINGLE: begin
					if (ch_s1 == qwt_pkg::CH_SQUOTE) begin
						qm_d = qwt_pkg::QM_OUT;
					end else begin
						push.vld[0] = 1'b1;
						push.r0     = qwt_pkg::char_res(ch_s1);
						len_d       = len1;
					end
				end
				qwt_pkg::QM_DOUBLE: begin
					if (pend_q) begin
						pend_d = 1'b0;
						if ((ch_s1 == qwt_pkg::CH_DQUOTE) || (ch_s1 == qwt_pkg::CH_BSLASH)) begin
							push.vld[0] = 1'b1;
							push.r0     = qwt_pkg::char_res(ch_s1);
							len_d       = len1;
						end else begin
							// The held backslash goes out first; a limit hit on it
							// drops the following character.
							push.vld[0] = 1'b1;
							push.r0     = qwt_pkg::char_res(qwt_pkg::CH_BSLASH);
							len_d       = len1;
							if (mid != qwt_pkg::ST_OK) begin
								err_d = mid;
							end else begin
								push.vld[1] = 1'b1;
								push.r1     = qwt_pkg::char_res(ch_s1);
								len_d       = qwt_pkg::len_inc(len1);
							end
						end
					end else if (ch_s1 == qwt_pkg::CH_DQUOTE) begin
						qm_d = qwt_pkg::QM_OUT;
					end else if (ch_s1 == qwt_pkg::CH_BSLASH) begin
						pend_d = 1'b1;
					end else begin
						push.vld[0] = 1'b1;
						push.r0     = qwt_pkg::char_res(ch_s1);
						len_d       = len1;
					end
				end
				default: begin
					if (is_sep) begin
						if (len_q != '0) begin
							push.vld[0]      = 1'b1;
							push.r0.word_end = 1'b1;
							len_d            = '0;
							cnt_d            = cnt1;
						end
					end else if (ch_s1 == qwt_pkg::CH_SQUOTE) begin
						qm_d = qwt_pkg::QM_SINGLE;
					end else if (ch_s1 == qwt_pkg::CH_DQUOTE) begin
						qm_d = qwt_pkg::QM_DOUBLE;
					end else begin
						push.vld[0] = 1'b1;
						push.r0     = qwt_pkg::char_res(ch_s1);
						len_d       = len1;
					end
				end
			endcase
			if (err_d == qwt_pkg::ST_OK) begin
				err_d = qwt_pkg::limit_check(len_d, cnt_d, len_limit_q, cnt_limit_q);
			end
		end

		if (!fire) begin
			push.vld = 2'b00;
		end
	end

	`QWT_ASSERT(a_line_end_clears, clk, arst_n, (fire && done_s1) |=> (qm_q == qwt_pkg::QM_OUT && err_q == qwt_pkg::ST_OK && len_q == '0 && cnt_q == '0 && !pend_q))
	`QWT_NEVER(a_silent_after_error, clk, arst_n, fire && !done_s1 && err_q != qwt_pkg::ST_OK && push.vld[0])
	`QWT_NEVER(a_pend_only_in_double, clk, arst_n, pend_q && qm_q != qwt_pkg::QM_DOUBLE)
	`QWT_NEVER(a_push_needs_room, clk, arst_n, push.vld[0] && !room)

endmodule

// ----- hw/rtl/qwt_fifo.sv -----
`include "assert_macros.svh"

module qwt_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  qwt_pkg::push_t   push,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output qwt_pkg::res_t    head
);

	qwt_pkg::res_t                  mem_q [qwt_pkg::FIFO_DEPTH];
	logic [qwt_pkg::FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [qwt_pkg::FIFO_CW-1:0]    count_q;
	logic                           pop;
	logic [qwt_pkg::FIFO_CW-1:0]    n_push;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_ptr_q];
	// Room is reserved for the worst case of two results per transaction.
	assign room      = (count_q <= qwt_pkg::FIFO_CW'(qwt_pkg::FIFO_DEPTH - 2));
	assign n_push    = qwt_pkg::FIFO_CW'(push.vld[0]) + qwt_pkg::FIFO_CW'(push.vld[1]);

	always_ff @(posedge clk) begin
		if (push.vld[0]) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.vld[1]) begin
			mem_q[wr_ptr_q + qwt_pkg::FIFO_AW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[qwt_pkg::FIFO_AW-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + qwt_pkg::FIFO_AW'(1);
			end
			count_q <= count_q + n_push - qwt_pkg::FIFO_CW'(pop);
		end
	end

	`QWT_NEVER(a_no_overflow, clk, arst_n, count_q > qwt_pkg::FIFO_CW'(qwt_pkg::FIFO_DEPTH))
	`QWT_NEVER(a_second_needs_first, clk, arst_n, push.vld[1] && !push.vld[0])
	`QWT_ASSERT(a_count_tracks, clk, arst_n, (count_q == '0 && push.vld == 2'b00) |=> (count_q == '0))

endmodule

// ----- hw/rtl/quoted_word_tokenizer.sv -----
// Shell-style word splitter. One character enters per transaction on tok_in and
// an item with line_done set ends the line. Word characters stream out on
// tok_out as they arrive, a result with word_end closes each word, and the
// last result of the line has line_end set and carries the status (ok, open
// quote, word too long, too many words); after an error the rest of the line
// gives no results, and the consumer drops the line's words on a bad status.
// An item is decoded in the cycle after it is accepted, while it sits in the
// input register; its results are queued and can leave in the next cycle. A
// new character is taken every cycle while the downstream keeps up. The
// four-entry result queue sets the limit: a backslash escape that is not
// followed by a quote or a backslash yields two results, and an item waits in
// the input register while the queue holds more than two results. Write limits
// via cfg_we/cfg_index/cfg_data only while the line is idle (not enforced).
module quoted_word_tokenizer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [qwt_pkg::LEN_W-1:0] cfg_data,
	qwt_in_if.sink                    tok_in,
	qwt_out_if.source                 tok_out
);

	qwt_pkg::push_t push;
	logic           room;
	qwt_pkg::res_t  head;

	qwt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (tok_in.valid),
		.in_ch     (tok_in.ch),
		.in_done   (tok_in.line_done),
		.in_ready  (tok_in.ready),
		.room      (room),
		.push      (push)
	);

	qwt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (tok_out.valid),
		.out_ready (tok_out.ready),
		.head      (head)
	);

	assign tok_out.word_char  = head.word_char;
	assign tok_out.char_valid = head.char_valid;
	assign tok_out.word_end   = head.word_end;
	assign tok_out.line_end   = head.line_end;
	assign tok_out.status     = head.status;

endmodule

// ----- dv/tok_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the tokenizer, tracks the limit registers from the
// write port, predicts the results of every input transaction and compares
// each output transaction with the oldest result still due.
module tok_checker
	import qwt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [LEN_W-1:0] cfg_data,
	qwt_in_if                tok_in,
	qwt_out_if               tok_out,
	output int               fail_count,
	output int               results_due,
	output int               live_items,
	output int               lines_done,
	output int               results_checked
);

	localparam int PRINT_CAP = 40;

	qmode_t           quote_state;
	logic             escape_held;
	logic [LEN_W-1:0] cur_len;
	logic [CNT_W-1:0] word_total;
	status_t          line_err;
	logic [LEN_W-1:0] len_limit;
	logic [CNT_W-1:0] cnt_limit;

	res_t due_q[$];
	int   n_fail;
	int   n_live;
	int   n_lines;
	int   n_checked;

	task automatic flag_mismatch(input string msg);
		n_fail++;
		if (n_fail <= PRINT_CAP)
			$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	task automatic queue_result(input logic [CHAR_W-1:0] c, input logic cv, input logic wend,
		input logic lend, input status_t st);
		res_t r;
		r.word_char  = c;
		r.char_valid = cv;
		r.word_end   = wend;
		r.line_end   = lend;
		r.status     = st;
		due_q.push_back(r);
	endtask

	task automatic emit_char(input logic [CHAR_W-1:0] c);
		queue_result(c, 1'b1, 1'b0, 1'b0, ST_OK);
		if (cur_len != LEN_MAX)
			cur_len = cur_len + 1'b1;
	endtask

	task automatic close_word();
		cur_len = '0;
		if (word_total != CNT_MAX)
			word_total = word_total + 1'b1;
	endtask

	// The first limit that trips stays as the line's error.
	task automatic apply_limits();
		if (line_err == ST_OK) begin
			if (cur_len >= len_limit)
				line_err = ST_TOO_LONG;
			else if (word_total >= cnt_limit)
				line_err = ST_TOO_MANY;
		end
	endtask

	task automatic clear_line();
		quote_state = QM_OUT;
		escape_held = 1'b0;
		cur_len     = '0;
		word_total  = '0;
		line_err    = ST_OK;
	endtask

	task automatic tokenize_item(input logic [CHAR_W-1:0] c, input logic done);
		status_t st;
		logic    closed;
		if (done) begin
			st     = line_err;
			closed = 1'b0;
			if (st == ST_OK) begin
				if (quote_state != QM_OUT) begin
					st = ST_OPEN_QUOTE;
				end else begin
					if (cur_len != '0) begin
						closed = 1'b1;
						close_word();
					end
					apply_limits();
					st = line_err;
				end
			end
			queue_result('0, 1'b0, closed, 1'b1, st);
			clear_line();
			n_live++;
			n_lines++;
		end else if (line_err == ST_OK) begin
			n_live++;
			case (quote_state)
				QM_SINGLE: begin
					if (c == CH_SQUOTE)
						quote_state = QM_OUT;
					else
						emit_char(c);
				end
				QM_DOUBLE: begin
					if (escape_held) begin
						escape_held = 1'b0;
						if (c == CH_DQUOTE || c == CH_BSLASH) begin
							emit_char(c);
						end else begin
							// The held backslash goes out first and may itself hit the limit.
							emit_char(CH_BSLASH);
							apply_limits();
							if (line_err == ST_OK)
								emit_char(c);
						end
					end else if (c == CH_DQUOTE) begin
						quote_state = QM_OUT;
					end else if (c == CH_BSLASH) begin
						escape_held = 1'b1;
					end else begin
						emit_char(c);
					end
				end
				default: begin
					if (c == CH_SPACE || c == CH_TAB) begin
						if (cur_len != '0) begin
							queue_result('0, 1'b0, 1'b1, 1'b0, ST_OK);
							close_word();
						end
					end else if (c == CH_SQUOTE) begin
						quote_state = QM_SINGLE;
					end else if (c == CH_DQUOTE) begin
						quote_state = QM_DOUBLE;
					end else begin
						emit_char(c);
					end
				end
			endcase
			apply_limits();
		end
	endtask

	task automatic check_result();
		res_t want;
		n_checked++;
		if (due_q.size() == 0) begin
			flag_mismatch($sformatf("result %0d with nothing due: char %02h line_end %0b",
				n_checked, tok_out.word_char, tok_out.line_end));
		end else begin
			want = due_q.pop_front();
			if (tok_out.word_char !== want.word_char)
				flag_mismatch($sformatf("result %0d word_char %02h, expected %02h",
					n_checked, tok_out.word_char, want.word_char));
			if (tok_out.char_valid !== want.char_valid)
				flag_mismatch($sformatf("result %0d char_valid %0b, expected %0b",
					n_checked, tok_out.char_valid, want.char_valid));
			if (tok_out.word_end !== want.word_end)
				flag_mismatch($sformatf("result %0d word_end %0b, expected %0b",
					n_checked, tok_out.word_end, want.word_end));
			if (tok_out.line_end !== want.line_end)
				flag_mismatch($sformatf("result %0d line_end %0b, expected %0b",
					n_checked, tok_out.line_end, want.line_end));
			if (tok_out.status !== want.status)
				flag_mismatch($sformatf("result %0d status %0d, expected %0d",
					n_checked, tok_out.status, want.status));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			len_limit = LEN_LIMIT_RST;
			cnt_limit = CNT_LIMIT_RST;
			due_q.delete();
			fail_count      <= 0;
			results_due     <= 0;
			live_items      <= 0;
			lines_done      <= 0;
			results_checked <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_LEN_LIMIT)
					len_limit = cfg_data;
				else if (cfg_index == REG_CNT_LIMIT)
					cnt_limit = cfg_data[CNT_W-1:0];
			end
			if (tok_in.valid && tok_in.ready)
				tokenize_item(tok_in.ch, tok_in.line_done);
			if (tok_out.valid && tok_out.ready)
				check_result();
			fail_count      <= n_fail;
			results_due     <= due_q.size();
			live_items      <= n_live;
			lines_done      <= n_lines;
			results_checked <= n_checked;
		end
	end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import qwt_pkg::*;

	localparam int TOTAL_ITEMS  = 800;
	localparam int GAP_MAX      = 12;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 300;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [0:0]       cfg_index;
	logic [LEN_W-1:0] cfg_data;

	int fail_count;
	int results_due;
	int live_items;
	int lines_done;
	int results_checked;

	bit send_burst;
	bit recv_burst;
	int hold_request;
	int settings_used;
	int items_sent;

	qwt_in_if  tok_in (clk);
	qwt_out_if tok_out (clk);

	quoted_word_tokenizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tok_in    (tok_in),
		.tok_out   (tok_out)
	);

	tok_checker check_u (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.tok_in          (tok_in),
		.tok_out         (tok_out),
		.fail_count      (fail_count),
		.results_due     (results_due),
		.live_items      (live_items),
		.lines_done      (lines_done),
		.results_checked (results_checked)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d results still due", results_due);
		$display("*** FAILED ***");
		$finish;
	end

	// Receiver: a random wait before each transaction outside bursts, and a long hold-off on request.
	initial begin
		int hold;
		tok_out.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				hold = hold_request;
				hold_request = 0;
			end else begin
				hold = recv_burst ? 0 : $urandom_range(0, GAP_MAX);
			end
			if (hold > 0) begin
				tok_out.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			tok_out.ready <= 1'b1;
			do @(posedge clk); while (!tok_out.valid);
		end
	end

	// Valid stays up into the next item when no gap is drawn.
	task automatic send_item(input logic [CHAR_W-1:0] c, input logic done);
		int gap;
		items_sent++;
		tok_in.valid     <= 1'b1;
		tok_in.ch        <= c;
		tok_in.line_done <= done;
		do @(posedge clk); while (!tok_in.ready);
		gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			tok_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_item(s[i], 1'b0);
	endtask

	task automatic end_line();
		send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic wait_idle();
		tok_in.valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limits(input int len_lim, input int cnt_lim);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_LEN_LIMIT;
		cfg_data  <= LEN_W'(len_lim);
		@(posedge clk);
		cfg_index <= REG_CNT_LIMIT;
		cfg_data  <= LEN_W'(cnt_lim);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [CHAR_W-1:0] plain_char();
		logic [CHAR_W-1:0] c;
		do
			c = CHAR_W'($urandom_range(0, 255));
		while (c == CH_SPACE || c == CH_TAB || c == CH_SQUOTE || c == CH_DQUOTE);
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] noise_char();
		case ($urandom_range(0, 7))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_SQUOTE;
			3: return CH_DQUOTE;
			4: return CH_BSLASH;
			default: return CHAR_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic single_piece(input bit broken);
		logic [CHAR_W-1:0] c;
		send_item(CH_SQUOTE, 1'b0);
		repeat ($urandom_range(0, 5)) begin
			do c = CHAR_W'($urandom_range(0, 255)); while (c == CH_SQUOTE);
			send_item(c, 1'b0);
		end
		if (!broken)
			send_item(CH_SQUOTE, 1'b0);
	endtask

	task automatic double_piece(input bit broken);
		logic [CHAR_W-1:0] c;
		send_item(CH_DQUOTE, 1'b0);
		repeat ($urandom_range(0, 5)) begin
			if ($urandom_range(0, 3) == 0) begin
				// Any character may follow the backslash; only two of them are escapes.
				send_item(CH_BSLASH, 1'b0);
				case ($urandom_range(0, 2))
					0: send_item(CH_DQUOTE, 1'b0);
					1: send_item(CH_BSLASH, 1'b0);
					default: send_item(CHAR_W'($urandom_range(0, 255)), 1'b0);
				endcase
			end else begin
				do c = CHAR_W'($urandom_range(0, 255)); while (c == CH_DQUOTE || c == CH_BSLASH);
				send_item(c, 1'b0);
			end
		end
		if (!broken)
			send_item(CH_DQUOTE, 1'b0);
	endtask

	// Mostly well-formed lines of joined plain and quoted pieces; some noise,
	// some unclosed quotes, and now and then a pause until all results are in.
	task automatic random_line();
		bit broken;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(0, 24)) send_item(noise_char(), 1'b0);
		end else begin
			repeat ($urandom_range(0, 6)) begin
				repeat ($urandom_range(1, 2)) send_item($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
				repeat ($urandom_range(1, 3)) begin
					broken = ($urandom_range(0, 15) == 0);
					case ($urandom_range(0, 2))
						0: repeat ($urandom_range(1, 6)) send_item(plain_char(), 1'b0);
						1: single_piece(broken);
						default: double_piece(broken);
					endcase
				end
				if ($urandom_range(0, 31) == 0)
					wait_idle();
			end
			if ($urandom_range(0, 1) == 0)
				send_item(CH_SPACE, 1'b0);
		end
		end_line();
	endtask

	initial begin
		arst_n           = 1'b0;
		tok_in.valid     <= 1'b0;
		tok_in.ch        <= '0;
		tok_in.line_done <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_LEN_LIMIT;
		cfg_data         <= '0;
		send_burst       = 1'b0;
		recv_burst       = 1'b0;
		hold_request     = 0;
		settings_used    = 1;
		items_sent       = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limits: separators, character zero and all-ones, quotes joined onto one word,
		// and inside double quotes an escaped quote, an escaped backslash and a plain backslash.
		send_item(CH_TAB, 1'b0);
		send_text(" a");
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_text("' \"'");
		send_text("\"\\\"\\\\\\q\"");
		end_line();
		send_text("\"\"''");
		end_line();
		send_text("'z");
		end_line();
		send_text("\"y\\");
		end_line();

		// A backslash that reaches the length limit drops the character after it;
		// the count limit trips both on a separator and on the close at line end.
		write_limits(2, 1);
		send_text("\"a\\b");
		end_line();
		send_text("a b");
		end_line();
		send_text("a");
		end_line();

		// Largest limits with back-to-back traffic on both sides; the word count
		// limit is reached.
		write_limits(LEN_MAX, CNT_MAX);
		send_burst = 1'b1;
		recv_burst = 1'b1;
		repeat (96) send_item("w", 1'b0);
		end_line();
		repeat (int'(CNT_MAX) + 1) send_text("v ");
		end_line();

		// The receiver holds off while the sender keeps offering a long word.
		hold_request = LONG_HOLD;
		repeat (40) send_item(plain_char(), 1'b0);
		end_line();
		send_text("ab");
		wait_idle();
		send_text("c");
		end_line();

		while (items_sent < TOTAL_ITEMS) begin
			case ($urandom_range(0, 5))
				0: write_limits(1, 1);
				1: write_limits(LEN_MAX, CNT_MAX);
				2: write_limits($urandom_range(1, LEN_MAX), $urandom_range(1, CNT_MAX));
				default: write_limits($urandom_range(1, 16), $urandom_range(1, 8));
			endcase
			send_burst = ($urandom_range(0, 3) == 0);
			recv_burst = ($urandom_range(0, 3) == 0);
			repeat (4) random_line();
		end

		wait_idle();
		$display("Run covered %0d lines and %0d items, %0d of which reached the tokenizer, under %0d limit settings.",
			lines_done, items_sent, live_items, settings_used);
		$display("%0d results checked, %0d mismatches.", results_checked, fail_count);
		if (fail_count == 0 && results_due == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
